// ----- rtl/substring_search_defines.svh -----
// Assertion macros shared by the substring search RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef SUBSTRING_SEARCH_DEFINES_SVH
`define SUBSTRING_SEARCH_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("substring_search: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define SS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("substring_search: next-cycle check failed");

`endif

// ----- rtl/ss_pkg.sv -----
// Shared constants, types and helpers for the substring search block.
// No dependencies; used by ss_match and substring_search.
package ss_pkg;

    localparam int NEEDLE_MAX    = 16;
    localparam int POSITION_BITS = 32;
    localparam int NEEDLE_IDX_W  = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam int LEN_W         = 5;
    localparam int NEEDLE_BITS   = 128;
    localparam int START_W       = 32;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    typedef enum logic [1:0] {
        REG_NEEDLE_LOW    = 2'd0,
        REG_NEEDLE_HIGH   = 2'd1,
        REG_NEEDLE_LENGTH = 2'd2,
        REG_CASE_FOLD     = 2'd3
    } ss_reg_t;

    // Entry 0 is the newest byte
    typedef logic [NEEDLE_MAX-1:0][7:0] ss_window_t;

    typedef struct packed {
        logic [NEEDLE_BITS-1:0] needle;
        logic [LEN_W-1:0]       length;
        logic                   case_fold;
    } ss_cfg_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && (b >= 8'h41) && (b <= 8'h5A))
            r = b + 8'd32;
        return r;
    endfunction

endpackage

// ----- rtl/ss_match.sv -----
// Parallel window compare: does the needle end exactly at the newest byte.
// Depends on ss_pkg.
module ss_match (
    input  ss_pkg::ss_window_t        window,
    input  ss_pkg::ss_cfg_t           cfg,
    output logic [ss_pkg::LEN_W-1:0]  len_eff,
    output logic                      hit
);

    logic [ss_pkg::LEN_W-1:0] nidx;
    logic [7:0]               nbyte;

    always_comb
    begin
        if (cfg.length > ss_pkg::LEN_W'(ss_pkg::NEEDLE_MAX))
            len_eff = ss_pkg::LEN_W'(ss_pkg::NEEDLE_MAX);
        else
            len_eff = cfg.length;
    end

    // Window entry j lines up with needle byte len_eff-1-j
    always_comb
    begin
        nidx  = '0;
        nbyte = '0;
        hit   = (len_eff != '0);
        for (int j = 0; j < ss_pkg::NEEDLE_MAX; j++)
        begin
            nidx  = len_eff - ss_pkg::LEN_W'(j) - ss_pkg::LEN_W'(1);
            nbyte = cfg.needle[8*nidx[ss_pkg::NEEDLE_IDX_W-1:0] +: 8];
            if ((ss_pkg::LEN_W'(j) < len_eff) &&
                (ss_pkg::fold_byte(window[j], cfg.case_fold) !=
                 ss_pkg::fold_byte(nbyte, cfg.case_fold)))
                hit = 1'b0;
        end
    end

endmodule

// ----- rtl/substring_search.sv -----
// Streaming first-occurrence substring search over a byte haystack.
// The end_of_text byte is captured in the input register, then loads the result register.
// Throughput: one byte per cycle unless stalled; the combinational window compare sets the rate.
// Input stalls only when a last byte meets a result that is still held.
// Reset (rst_n, async, active low) clears config, position, match state and valid flags.
// Depends on ss_pkg, ss_match and substring_search_defines.svh.
`include "substring_search_defines.svh"

module substring_search (
    input  logic        clk,
    input  logic        rst_n,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,

    // haystack byte channel
    input  logic        text_valid,
    output logic        text_stall,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,

    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic        found,
    output logic [31:0] match_start,
    output logic        overflow
);

    localparam int PB = ss_pkg::POSITION_BITS;

    // ------------------------------------------------------------------
    // Configuration registers: always ready; user must write only while idle (unchecked).
    // ------------------------------------------------------------------
    ss_pkg::ss_cfg_t cfg_reg;
    ss_pkg::ss_cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (ss_pkg::ss_reg_t'(cfg_index))
                ss_pkg::REG_NEEDLE_LOW:    cfg_next.needle[63:0]   = cfg_data;
                ss_pkg::REG_NEEDLE_HIGH:   cfg_next.needle[127:64] = cfg_data;
                ss_pkg::REG_NEEDLE_LENGTH: cfg_next.length    = cfg_data[ss_pkg::LEN_W-1:0];
                ss_pkg::REG_CASE_FOLD:     cfg_next.case_fold = cfg_data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register: capture each accepted transaction.
    // ------------------------------------------------------------------
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_eot_reg;
    logic       s1_advance;
    logic       text_accept;

    // A last byte moves on only if the result register is free or draining
    assign s1_advance  = s1_valid_reg && (!s1_eot_reg || !result_valid || !result_stall);
    assign text_stall  = s1_valid_reg && !s1_advance;
    assign text_accept = text_valid && !text_stall;

    always_comb
    begin
        priority if (text_accept)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    // ------------------------------------------------------------------
    // Stream state: window, position counter, first match.
    // ------------------------------------------------------------------
    ss_pkg::ss_window_t window_reg, window_next, window_shift;
    logic [PB-1:0]      pos_reg, pos_next, have;
    logic               match_seen_reg, match_seen_next;
    logic [PB-1:0]      first_idx_reg, first_idx_next;
    logic               sat_reg, sat_next;

    logic [ss_pkg::LEN_W-1:0] len_eff;
    logic                     hit;
    logic                     sat_now;
    logic                     match_now;

    // Shift the new byte in at entry 0
    always_comb
    begin
        window_shift[0] = s1_byte_reg;
        for (int i = 1; i < ss_pkg::NEEDLE_MAX; i++)
            window_shift[i] = window_reg[i-1];
    end

    ss_match u_match (
        .window  (window_shift),
        .cfg     (cfg_reg),
        .len_eff (len_eff),
        .hit     (hit)
    );

    // Saturating byte count; have is the count including this byte
    assign sat_now   = (pos_reg == ss_pkg::POS_MAX);
    assign have      = sat_now ? pos_reg : pos_reg + PB'(1);
    // Match must lie wholly inside this haystack
    assign match_now = !match_seen_reg && hit && (have >= PB'(len_eff));

    always_comb
    begin
        window_next     = window_reg;
        pos_next        = pos_reg;
        match_seen_next = match_seen_reg;
        first_idx_next  = first_idx_reg;
        sat_next        = sat_reg;
        if (s1_advance)
        begin
            window_next = window_shift;
            if (s1_eot_reg)
            begin
                // drop stream state for the next haystack; old window bytes
                // are never compared because of the length guard
                pos_next        = '0;
                match_seen_next = 1'b0;
                sat_next        = 1'b0;
            end
            else
            begin
                pos_next = have;
                sat_next = sat_reg || sat_now;
                if (match_now)
                begin
                    match_seen_next = 1'b1;
                    first_idx_next  = have - PB'(len_eff);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register: loaded by the last byte, held while stalled.
    // ------------------------------------------------------------------
    logic          result_valid_reg, result_valid_next;
    logic          found_reg, found_next;
    logic [31:0]   start_reg, start_next;
    logic          overflow_reg, overflow_next;
    logic          result_load;
    logic          fin_seen;
    logic [PB-1:0] fin_idx;

    assign result_load = s1_advance && s1_eot_reg;
    assign fin_seen    = match_seen_reg || match_now;
    assign fin_idx     = match_seen_reg ? first_idx_reg : have - PB'(len_eff);

    always_comb
    begin
        priority if (result_load)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_comb
    begin
        found_next    = found_reg;
        start_next    = start_reg;
        overflow_next = overflow_reg;
        if (result_load)
        begin
            found_next    = fin_seen;
            start_next    = fin_seen ? ss_pkg::START_W'(fin_idx) : '0;
            overflow_next = sat_reg || sat_now;
        end
    end

    assign result_valid = result_valid_reg;
    assign found        = found_reg;
    assign match_start  = start_reg;
    assign overflow     = overflow_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            pos_reg          <= '0;
            match_seen_reg   <= 1'b0;
            sat_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg          <= cfg_next;
            s1_valid_reg     <= s1_valid_next;
            pos_reg          <= pos_next;
            match_seen_reg   <= match_seen_next;
            sat_reg          <= sat_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (text_accept)
        begin
            s1_byte_reg <= text_byte;
            s1_eot_reg  <= end_of_text;
        end
        window_reg    <= window_next;
        first_idx_reg <= first_idx_next;
        found_reg     <= found_next;
        start_reg     <= start_next;
        overflow_reg  <= overflow_next;
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `SS_ASSERT_SAME(a_stall_cause, text_stall, s1_eot_reg && result_valid_reg && result_stall)
    `SS_ASSERT_SAME(a_miss_zero, result_valid_reg && !found_reg, start_reg == '0)
    `SS_ASSERT_NEXT(a_clear_after_last, result_load,
                    result_valid_reg && (pos_reg == '0) && !match_seen_reg && !sat_reg)

endmodule

// ----- verif/tb_substring_search.sv -----
// Self-checking bench for substring_search: streams haystacks byte by byte,
// predicts each end-of-text result in a scoreboard and compares field by field.
// Depends on ss_pkg and the substring_search RTL; needs no other files.
module tb_substring_search;

    // Cycles with no transaction on any channel before the run is declared hung
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASES      = 8;
    localparam int PHASE_BYTES = 48;

    // Needle settings per random phase: lengths cover empty, one byte, the full
    // window and a length beyond the window (clamped by the block)
    localparam int PHASE_LEN  [PHASES] = '{3, 16, 1, 0, 31, 6, 16, 2};
    localparam bit PHASE_FOLD [PHASES] = '{1, 0, 1, 0, 1, 1, 0, 0};

    typedef struct {
        logic [7:0] value;
        logic       last;
        logic       drain_first;   // hold this byte until every result is back
    } text_item_t;

    typedef struct {
        logic                       found;
        logic [ss_pkg::START_W-1:0] start;
        logic                       overflow;
    } search_outcome_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index    = ss_pkg::REG_NEEDLE_LOW;
    logic [63:0]        cfg_data     = '0;
    logic               text_valid   = 1'b0;
    logic               text_stall;
    logic [7:0]         text_byte    = '0;
    logic               end_of_text  = 1'b0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic               found;
    logic [31:0]        match_start;
    logic               overflow;

    // Stimulus and scoreboard
    text_item_t         text_backlog [$];
    search_outcome_t    search_outcomes [$];
    int                 send_idle_pct    = 0;
    int                 stall_pct        = 0;
    int                 bytes_queued     = 0;
    int                 bytes_accepted   = 0;
    int                 haystacks_queued = 0;
    int                 results_checked  = 0;
    int                 found_count      = 0;
    int                 settings_count   = 0;
    int                 error_count      = 0;
    int                 quiet_cycles     = 0;
    bit                 text_fire        = 1'b0;

    // Shadow of the configuration registers
    logic [ss_pkg::NEEDLE_BITS-1:0]   needle_bits = '0;
    logic [ss_pkg::LEN_W-1:0]         needle_len  = '0;
    logic                             fold_on     = 1'b0;

    // Predicted stream state
    ss_pkg::ss_window_t               recent_window  = '0;
    logic [ss_pkg::POSITION_BITS-1:0] bytes_seen     = '0;
    logic                             match_hit      = 1'b0;
    logic [ss_pkg::POSITION_BITS-1:0] match_index    = '0;
    logic                             seen_saturated = 1'b0;

    substring_search dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_byte    (text_byte),
        .end_of_text  (end_of_text),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found),
        .match_start  (match_start),
        .overflow     (overflow)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        error_count++;
        $display("[%0t] substring_search %s: got %0h, want %0h", $time, what, got, want);
    endtask

    // ASCII lower-casing, active only while case folding is configured
    function automatic logic [7:0] lower_ascii(input logic [7:0] b);
        return (fold_on && b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
    endfunction

    // Advance the predicted search by one haystack byte; on the last byte,
    // queue the expected result and clear the stream state.
    task automatic scan_byte(input logic [7:0] b, input logic last);
        int              span;
        bit              hit;
        search_outcome_t outcome;
        recent_window = {recent_window[ss_pkg::NEEDLE_MAX-2:0], b};
        if (bytes_seen == '1)
            seen_saturated = 1'b1;
        else
            bytes_seen++;
        span = (needle_len > ss_pkg::NEEDLE_MAX) ? ss_pkg::NEEDLE_MAX : int'(needle_len);
        // A match only counts once all of its bytes belong to this haystack
        if (!match_hit && span > 0 && bytes_seen >= span)
        begin
            hit = 1'b1;
            for (int w = 0; w < span; w++)
                if (lower_ascii(recent_window[span-1-w]) != lower_ascii(needle_bits[8*w +: 8]))
                    hit = 1'b0;
            if (hit)
            begin
                match_hit   = 1'b1;
                match_index = bytes_seen - span;
            end
        end
        if (last)
        begin
            outcome.found    = match_hit;
            outcome.start    = match_hit ? match_index[ss_pkg::START_W-1:0] : '0;
            outcome.overflow = seen_saturated;
            search_outcomes.push_back(outcome);
            recent_window  = '0;
            bytes_seen     = '0;
            match_hit      = 1'b0;
            match_index    = '0;
            seen_saturated = 1'b0;
        end
    endtask

    // Monitor: sample every channel at the rising edge. Check results before
    // predicting, since a result never belongs to the byte taken at the same edge.
    always @(posedge clk)
    begin
        search_outcome_t want;
        text_fire = rst_n && text_valid && !text_stall;
        if (rst_n && result_valid && !result_stall)
        begin
            results_checked++;
            if (search_outcomes.size() == 0)
                flag_mismatch("result with nothing pending", 32'(found), 32'd0);
            else
            begin
                want = search_outcomes.pop_front();
                if (found !== want.found)
                    flag_mismatch("found", 32'(found), 32'(want.found));
                if (match_start !== want.start)
                    flag_mismatch("match_start", match_start, want.start);
                if (overflow !== want.overflow)
                    flag_mismatch("overflow", 32'(overflow), 32'(want.overflow));
                if (want.found)
                    found_count++;
            end
        end
        if (text_fire)
        begin
            scan_byte(text_byte, end_of_text);
            bytes_accepted++;
        end
        if (text_fire || (rst_n && result_valid && !result_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // Driver: present the next byte once the previous transaction is taken.
    // Hold a stalled byte unchanged; idle at random with send_idle_pct.
    always @(negedge clk)
    begin
        logic       next_valid;
        logic [7:0] next_byte;
        logic       next_last;
        text_item_t head;
        if (rst_n && (!text_valid || text_fire))
        begin
            next_valid = 1'b0;
            next_byte  = text_byte;
            next_last  = end_of_text;
            if (text_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                head = text_backlog[0];
                // Pause the sender until every outstanding result has come back
                if (!head.drain_first || search_outcomes.size() == 0)
                begin
                    void'(text_backlog.pop_front());
                    next_valid = 1'b1;
                    next_byte  = head.value;
                    next_last  = head.last;
                end
            end
            text_valid  <= next_valid;
            text_byte   <= next_byte;
            end_of_text <= next_last;
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge clk);
        $display("tb_substring_search: errors");
        $finish;
    end

    task automatic push_byte(input logic [7:0] value, input logic last,
                             input logic drain_first);
        text_item_t item;
        item.value       = value;
        item.last        = last;
        item.drain_first = drain_first;
        text_backlog.push_back(item);
        bytes_queued++;
        if (last)
            haystacks_queued++;
    endtask

    task automatic push_text(input string s, input bit drain_first);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], i == s.len() - 1, drain_first && i == 0);
    endtask

    // Wait until every byte is taken and every result is back,
    // then let the block settle.
    task automatic wait_idle();
        while (bytes_accepted != bytes_queued || search_outcomes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input ss_pkg::ss_reg_t index, input logic [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            ss_pkg::REG_NEEDLE_LOW:    needle_bits[63:0]   = data;
            ss_pkg::REG_NEEDLE_HIGH:   needle_bits[127:64] = data;
            ss_pkg::REG_NEEDLE_LENGTH: needle_len          = data[ss_pkg::LEN_W-1:0];
            ss_pkg::REG_CASE_FOLD:     fold_on             = data[0];
            default:                   ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Write all four registers; junk in the unused upper bits must be ignored
    task automatic configure(input logic [63:0] low, input logic [63:0] high,
                             input int len, input bit fold);
        logic [63:0] data;
        write_reg(ss_pkg::REG_NEEDLE_LOW, low);
        write_reg(ss_pkg::REG_NEEDLE_HIGH, high);
        data = {$urandom(), $urandom()};
        data[ss_pkg::LEN_W-1:0] = ss_pkg::LEN_W'(len);
        write_reg(ss_pkg::REG_NEEDLE_LENGTH, data);
        data = {$urandom(), $urandom()};
        data[0] = fold;
        write_reg(ss_pkg::REG_CASE_FOLD, data);
        settings_count++;
    endtask

    // Bytes from a small alphabet so that needles and haystacks collide often,
    // with the case-fold boundaries and the byte extremes mixed in
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(4))
            0: return 8'h61 + 8'($urandom_range(3));
            1: return 8'h41 + 8'($urandom_range(3));
            2:
            begin
                case ($urandom_range(3))
                    0: return 8'h40;
                    1: return 8'h5B;
                    2: return 8'h60;
                    default: return 8'h7B;
                endcase
            end
            3: return $urandom_range(1) ? 8'h00 : 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // One haystack: mostly a copy of the needle in random surroundings, with
    // case flips, single-byte damage, partial-needle lead-ins and pure noise.
    task automatic add_random_haystack();
        int         eff;
        int         kind;
        int         cut;
        logic [7:0] b;
        logic [7:0] hay [$];
        eff  = (needle_len > ss_pkg::NEEDLE_MAX) ? ss_pkg::NEEDLE_MAX : int'(needle_len);
        kind = $urandom_range(9);
        if (kind <= 5 || kind == 9)
        begin
            repeat ($urandom_range(5)) hay.push_back(pick_byte());
            if (kind == 9 && eff > 1)
            begin
                cut = $urandom_range(eff - 1, 1);
                for (int w = 0; w < cut; w++)
                    hay.push_back(needle_bits[8*w +: 8]);
            end
            for (int w = 0; w < eff; w++)
            begin
                b = needle_bits[8*w +: 8];
                if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A
                    && $urandom_range(99) < (fold_on ? 50 : 10))
                    b ^= 8'h20;
                hay.push_back(b);
            end
            if (hay.size() != 0 && $urandom_range(7) == 0)
                hay[$urandom_range(hay.size() - 1)] = pick_byte();
            repeat ($urandom_range(3)) hay.push_back(pick_byte());
        end
        else if (kind <= 7)
            repeat ($urandom_range(12, 1)) hay.push_back(pick_byte());
        else
            repeat ($urandom_range(20, 1)) hay.push_back(8'($urandom_range(255)));
        if (hay.size() == 0)
            hay.push_back(pick_byte());
        for (int i = 0; i < hay.size(); i++)
            push_byte(hay[i], i == hay.size() - 1, i == 0 && $urandom_range(15) == 0);
    endtask

    initial
    begin
        logic [ss_pkg::NEEDLE_BITS-1:0] fresh;
        int                             target;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: the empty needle out of reset never matches, even on 00/FF
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b0);
        wait_idle();

        // Needle "aBc", exact compare: match at the very start, a haystack
        // shorter than the needle, a wrong-case miss, and a later second match
        // that must not replace the first one
        configure(64'h0000_0000_0063_4261, 64'h0, 3, 1'b0);
        push_text("aBc", 1'b0);
        push_text("aB", 1'b1);
        push_text("abc", 1'b0);
        push_text("qaBcaBc", 1'b0);
        wait_idle();

        // Same needle, case-insensitive
        configure(64'h0000_0000_0063_4261, 64'h0, 3, 1'b1);
        push_text("xABC", 1'b0);
        wait_idle();

        // Random phases: walk through every idling mode and needle setting
        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0:
                begin
                    send_idle_pct <= 0;
                    stall_pct     <= 0;
                end
                1:
                begin
                    send_idle_pct <= 84;
                    stall_pct     <= 0;
                end
                2:
                begin
                    send_idle_pct <= 0;
                    stall_pct     <= 84;
                end
                default:
                begin
                    send_idle_pct <= 15;
                    stall_pct     <= 15;
                end
            endcase
            for (int k = 0; k < ss_pkg::NEEDLE_MAX; k++)
                fresh[8*k +: 8] = pick_byte();
            configure(fresh[63:0], fresh[127:64], PHASE_LEN[p], PHASE_FOLD[p]);
            target = bytes_queued + PHASE_BYTES;
            while (bytes_queued < target)
                add_random_haystack();
            wait_idle();
        end

        $display("summary: %0d bytes in %0d haystacks over %0d needle settings",
                 bytes_accepted, haystacks_queued, settings_count);
        $display("summary: %0d results checked, %0d with a match, %0d mismatches",
                 results_checked, found_count, error_count);
        if (error_count == 0)
            $display("tb_substring_search: clean");
        else
            $display("tb_substring_search: errors");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ss_pkg.sv
rtl/ss_match.sv
rtl/substring_search.sv
verif/tb_substring_search.sv
